// ===== hw/rtl/smrb_pkg.sv =====
// shared types, word map, bit positions and helper functions of the spi master register block
package smrb_pkg;

    // build constants
    localparam int CS_LINES   = 6;
    localparam int CS_OUT     = 6;
    localparam int FIFO_BYTES = 64;
    localparam int REG_WORDS  = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [6:0] CAP_FULL  = 7'(FIFO_BYTES);
    localparam logic [6:0] CAP_UPPER = (FIFO_BYTES > 32) ? 7'(FIFO_BYTES - 32) : 7'd0;

    // word map
    localparam logic [5:0] W_CMD   = 6'd0;
    localparam logic [5:0] W_ADDR  = 6'd1;
    localparam logic [5:0] W_USER  = 6'd4;
    localparam logic [5:0] W_USER1 = 6'd5;
    localparam logic [5:0] W_USER2 = 6'd6;
    localparam logic [5:0] W_DLEN  = 6'd7;
    localparam logic [5:0] W_MISC  = 6'd8;
    localparam logic [5:0] W_DMA   = 6'd12;
    localparam logic [5:0] W_ENA   = 6'd13;
    localparam logic [5:0] W_CLR   = 6'd14;
    localparam logic [5:0] W_RAW   = 6'd15;
    localparam logic [5:0] W_ST    = 6'd16;
    localparam logic [5:0] W_SET   = 6'd17;
    localparam logic [5:0] W_FIFO  = 6'd38;
    localparam logic [5:0] W_FIFO_UPPER = 6'd8;

    localparam logic [31:0] MISC_RESET = 32'h0000_003F;

    // bit positions
    localparam int B_CMD_UPDATE = 23;
    localparam int B_CMD_USR    = 24;
    localparam int B_USER_CMD   = 31;
    localparam int B_USER_ADDR  = 30;
    localparam int B_USER_DATA  = 27;
    localparam int B_USER_HALF  = 25;
    localparam int B_DMA_EN     = 28;
    localparam int B_MISC_KEEP  = 30;
    localparam int B_RAW_DONE   = 12;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    typedef enum logic {
        KIND_RESP = 1'b0,
        KIND_SPI  = 1'b1
    } t_kind;

    typedef enum logic {
        F_IDLE,
        F_EXEC
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_CMD,
        B_ADDR,
        B_FETCH,
        B_DATA,
        B_RESP
    } t_back_state;

    // one classified request handed from front to back
    typedef struct packed {
        logic        is_xfer;
        logic        send;
        logic [31:0] read_data;
        logic [5:0]  cs_resp;
        logic        irq_resp;
        logic [5:0]  cs_act;
        logic        irq_act;
        logic [2:0]  cmd_cnt;
        logic [31:0] cmd_bytes;
        logic [2:0]  addr_cnt;
        logic [31:0] addr_bytes;
        logic [6:0]  data_len;
        logic        upper;
    } t_job;

    // chip select levels for the given misc word
    function automatic logic [CS_OUT-1:0] cs_drive(input logic [31:0] misc, input logic active);
        logic [CS_OUT-1:0] lvl;
        lvl = '0;
        for (int c = 0; c < CS_OUT; c++) begin
            if (c < CS_LINES) begin
                lvl[c] = ~(active & ~misc[c]) ^ misc[c + 7];
            end
        end
        return lvl;
    endfunction

    // left-aligned value to byte group, first byte in bits 7:0
    function automatic logic [31:0] pack_phase(input logic [31:0] value, input logic [2:0] n);
        logic [31:0] packed_bytes;
        packed_bytes = '0;
        for (int i = 0; i < 4; i++) begin
            if (3'(i) < n) begin
                packed_bytes[8*i +: 8] = value[(31 - 8*i) -: 8];
            end
        end
        return packed_bytes;
    endfunction

endpackage

// ===== hw/rtl/smrb_regmem.sv =====
// register file storage, one write port and two registered read ports, valid bit per word
module smrb_regmem (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_we,
    input  logic [5:0]  i_waddr,
    input  logic [31:0] i_wdata,
    input  logic [5:0]  i_raddr_a,
    output logic [31:0] o_rdata_a,
    input  logic [5:0]  i_raddr_b,
    output logic [31:0] o_rdata_b
);
    import smrb_pkg::*;

    logic [31:0]          r_mem [REG_WORDS];
    logic [REG_WORDS-1:0] r_vld;
    logic [31:0]          r_data_a;
    logic [31:0]          r_data_b;
    logic                 r_vld_a;
    logic                 r_vld_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_data_a <= r_mem[i_raddr_a];
        r_data_b <= r_mem[i_raddr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_vld_a <= r_vld[i_raddr_a];
            r_vld_b <= r_vld[i_raddr_b];
        end
    end

    // words never written read as zero
    assign o_rdata_a = r_vld_a ? r_data_a : '0;
    assign o_rdata_b = r_vld_b ? r_data_b : '0;

endmodule

// ===== hw/rtl/smrb_queue.sv =====
// short request queue between front and back
module smrb_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  smrb_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output smrb_pkg::t_job o_head,
    output logic           o_empty
);
    import smrb_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_job          r_slot [QUEUE_DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            r_count <= r_count + CW'(i_push) - CW'(i_pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue pop while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

// ===== hw/rtl/smrb_front.sv =====
// front end: accepts accesses, updates control registers, classifies transfers
module smrb_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic           i_op,
    input  logic [5:0]     i_reg_word,
    input  logic [31:0]    i_write_data,
    input  logic [31:0]    i_mem_rdata,
    output logic           o_mem_we,
    output logic [5:0]     o_mem_waddr,
    output logic [31:0]    o_mem_wdata,
    input  logic           i_q_full,
    output logic           o_q_push,
    output smrb_pkg::t_job o_q_job,
    input  logic           i_xfer_done
);
    import smrb_pkg::*;

    t_front_state r_state, n_state;
    logic         r_busy;
    t_op          r_op;
    logic [5:0]   r_word;
    logic [31:0]  r_wdata;

    logic [31:0] r_cmd, n_cmd;
    logic [31:0] r_addr, n_addr;
    logic [31:0] r_user, n_user;
    logic [31:0] r_user1, n_user1;
    logic [31:0] r_user2, n_user2;
    logic [31:0] r_dlen, n_dlen;
    logic [31:0] r_misc, n_misc;
    logic [31:0] r_dma, n_dma;
    logic [31:0] r_ena, n_ena;
    logic [31:0] r_raw, n_raw;
    logic [CS_OUT-1:0] r_cs, n_cs;

    logic        accept;
    logic        exec_wr;
    logic        start_xfer;
    logic [31:0] rd_value;
    logic [4:0]  cbits;
    logic [5:0]  abits;
    logic [18:0] dlen_sum;
    logic [15:0] len_raw;
    logic [6:0]  cap;
    logic [6:0]  len_sat;
    logic [31:0] cmd_value;

    assign exec_wr    = (r_state == F_EXEC) && (r_op == OP_WRITE);
    assign start_xfer = exec_wr && (r_word == W_CMD) && r_wdata[B_CMD_USR];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (accept) begin
                n_state = F_EXEC;
            end
            F_EXEC: n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_stall     = (r_state != F_IDLE) || r_busy || i_q_full;
        accept      = i_valid && !o_stall;
        o_q_push    = (r_state == F_EXEC);
        o_mem_we    = exec_wr && (r_word != W_CLR) && (r_word != W_SET);
        o_mem_waddr = r_word;
        o_mem_wdata = r_wdata;
    end

    // register updates of the current write
    always_comb begin
        n_cmd   = r_cmd;
        n_addr  = r_addr;
        n_user  = r_user;
        n_user1 = r_user1;
        n_user2 = r_user2;
        n_dlen  = r_dlen;
        n_misc  = r_misc;
        n_dma   = r_dma;
        n_ena   = r_ena;
        n_raw   = r_raw;
        n_cs    = r_cs;
        if (exec_wr) begin
            unique case (r_word)
                W_CMD:   n_cmd   = r_wdata & ~(32'd1 << B_CMD_UPDATE);
                W_ADDR:  n_addr  = r_wdata;
                W_USER:  n_user  = r_wdata;
                W_USER1: n_user1 = r_wdata;
                W_USER2: n_user2 = r_wdata;
                W_DLEN:  n_dlen  = r_wdata;
                W_MISC:  n_misc  = r_wdata;
                W_DMA:   n_dma   = r_wdata;
                W_ENA:   n_ena   = r_wdata;
                W_RAW:   n_raw   = r_wdata;
                W_CLR:   n_raw   = r_raw & ~r_wdata;
                W_SET:   n_raw   = r_raw | r_wdata;
                default: ;
            endcase
        end
        // transfer completion effects
        if (start_xfer) begin
            n_cmd = '0;
            n_raw = n_raw | (32'd1 << B_RAW_DONE);
            n_cs  = cs_drive(r_misc, r_misc[B_MISC_KEEP]);
        end
    end

    // read value
    always_comb begin
        unique case (r_word)
            W_CMD:   rd_value = r_cmd;
            W_ADDR:  rd_value = r_addr;
            W_USER:  rd_value = r_user;
            W_USER1: rd_value = r_user1;
            W_USER2: rd_value = r_user2;
            W_DLEN:  rd_value = r_dlen;
            W_MISC:  rd_value = r_misc;
            W_DMA:   rd_value = r_dma;
            W_ENA:   rd_value = r_ena;
            W_RAW:   rd_value = r_raw;
            W_ST:    rd_value = r_raw & r_ena;
            default: rd_value = i_mem_rdata;
        endcase
    end

    // transfer classification
    always_comb begin
        cbits     = r_user[B_USER_CMD]  ? 5'({1'b0, r_user2[31:28]} + 5'd1) : 5'd0;
        abits     = r_user[B_USER_ADDR] ? 6'({1'b0, r_user1[31:27]} + 6'd1) : 6'd0;
        cmd_value = (cbits == 5'd16) ? (r_user2 << 16) : (r_user2 << 24);
        dlen_sum  = {1'b0, r_dlen[17:0]} + 19'd8;
        len_raw   = r_user[B_USER_DATA] ? dlen_sum[18:3] : 16'd0;
        if (r_dma[B_DMA_EN]) begin
            len_raw = '0;
        end
        cap     = r_user[B_USER_HALF] ? CAP_UPPER : CAP_FULL;
        len_sat = (len_raw > {9'd0, cap}) ? cap : len_raw[6:0];

        o_q_job.is_xfer    = start_xfer;
        o_q_job.send       = (cbits[2:0] == 3'd0) && (abits[2:0] == 3'd0);
        o_q_job.read_data  = (r_op == OP_READ) ? rd_value : '0;
        o_q_job.cs_resp    = n_cs;
        o_q_job.irq_resp   = |(n_raw & n_ena);
        o_q_job.cs_act     = cs_drive(r_misc, 1'b1);
        o_q_job.irq_act    = |(r_raw & r_ena);
        o_q_job.cmd_cnt    = {1'b0, cbits[4:3]};
        o_q_job.cmd_bytes  = pack_phase(cmd_value, {1'b0, cbits[4:3]});
        o_q_job.addr_cnt   = abits[5:3];
        o_q_job.addr_bytes = pack_phase(r_addr, abits[5:3]);
        o_q_job.data_len   = len_sat;
        o_q_job.upper      = r_user[B_USER_HALF];
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= t_op'(i_op);
            r_word  <= i_reg_word;
            r_wdata <= i_write_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_busy  <= 1'b0;
            r_cmd   <= '0;
            r_addr  <= '0;
            r_user  <= '0;
            r_user1 <= '0;
            r_user2 <= '0;
            r_dlen  <= '0;
            r_misc  <= MISC_RESET;
            r_dma   <= '0;
            r_ena   <= '0;
            r_raw   <= '0;
            r_cs    <= cs_drive(MISC_RESET, 1'b0);
        end else begin
            r_state <= n_state;
            if (start_xfer) begin
                r_busy <= 1'b1;
            end else if (i_xfer_done) begin
                r_busy <= 1'b0;
            end
            r_cmd   <= n_cmd;
            r_addr  <= n_addr;
            r_user  <= n_user;
            r_user1 <= n_user1;
            r_user2 <= n_user2;
            r_dlen  <= n_dlen;
            r_misc  <= n_misc;
            r_dma   <= n_dma;
            r_ena   <= n_ena;
            r_raw   <= n_raw;
            r_cs    <= n_cs;
        end
    end

endmodule

// ===== hw/rtl/smrb_back.sv =====
// back end: plays out byte groups and responses into the output register
module smrb_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  smrb_pkg::t_job i_q_head,
    output logic           o_q_pop,
    output logic [5:0]     o_mem_raddr,
    input  logic [31:0]    i_mem_rdata,
    output logic           o_xfer_done,
    output logic           o_valid,
    input  logic           i_stall,
    output logic           o_kind,
    output logic [31:0]    o_spi_bytes,
    output logic [2:0]     o_byte_count,
    output logic [31:0]    o_read_data,
    output logic [5:0]     o_cs_lines,
    output logic           o_irq_level,
    output logic           o_last
);
    import smrb_pkg::*;

    t_back_state r_state, n_state;
    t_job        r_job;
    logic [6:0]  r_rem;
    logic [5:0]  r_ptr;

    logic        r_out_valid;
    t_kind       r_out_kind;
    logic [31:0] r_out_bytes;
    logic [2:0]  r_out_cnt;
    logic [31:0] r_out_rdata;
    logic [5:0]  r_out_cs;
    logic        r_out_irq;
    logic        r_out_last;

    logic        out_free;
    logic        emit;
    t_kind       n_out_kind;
    logic [31:0] n_out_bytes;
    logic [2:0]  n_out_cnt;
    logic [2:0]  d_cnt;
    logic [31:0] d_mask;

    assign out_free    = !r_out_valid || !i_stall;
    assign o_mem_raddr = r_ptr;
    assign d_cnt       = (r_rem > 7'd4) ? 3'd4 : r_rem[2:0];

    always_comb begin
        unique case (d_cnt)
            3'd1:    d_mask = 32'h0000_00FF;
            3'd2:    d_mask = 32'h0000_FFFF;
            3'd3:    d_mask = 32'h00FF_FFFF;
            default: d_mask = 32'hFFFF_FFFF;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: if (!i_q_empty) begin
                priority if (!i_q_head.is_xfer || !i_q_head.send) n_state = B_RESP;
                else if (i_q_head.cmd_cnt != '0)                  n_state = B_CMD;
                else if (i_q_head.addr_cnt != '0)                 n_state = B_ADDR;
                else if (i_q_head.data_len != '0)                 n_state = B_FETCH;
                else                                              n_state = B_RESP;
            end
            B_CMD: if (out_free) begin
                priority if (r_job.addr_cnt != '0)  n_state = B_ADDR;
                else if (r_job.data_len != '0)      n_state = B_FETCH;
                else                                n_state = B_RESP;
            end
            B_ADDR: if (out_free) begin
                n_state = (r_job.data_len != '0) ? B_FETCH : B_RESP;
            end
            B_FETCH: n_state = B_DATA;
            B_DATA: if (out_free) begin
                n_state = (r_rem > 7'd4) ? B_FETCH : B_RESP;
            end
            B_RESP: if (out_free) begin
                n_state = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_q_pop     = (r_state == B_IDLE) && !i_q_empty;
        emit        = 1'b0;
        n_out_kind  = KIND_SPI;
        n_out_bytes = '0;
        n_out_cnt   = '0;
        o_xfer_done = 1'b0;
        unique case (r_state)
            B_CMD: begin
                emit        = out_free;
                n_out_bytes = r_job.cmd_bytes;
                n_out_cnt   = r_job.cmd_cnt;
            end
            B_ADDR: begin
                emit        = out_free;
                n_out_bytes = r_job.addr_bytes;
                n_out_cnt   = r_job.addr_cnt;
            end
            B_DATA: begin
                emit        = out_free;
                n_out_bytes = i_mem_rdata & d_mask;
                n_out_cnt   = d_cnt;
            end
            B_RESP: begin
                emit        = out_free;
                n_out_kind  = KIND_RESP;
                o_xfer_done = out_free && r_job.is_xfer;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job <= i_q_head;
        end
        if (emit) begin
            r_out_kind  <= n_out_kind;
            r_out_bytes <= n_out_bytes;
            r_out_cnt   <= n_out_cnt;
            r_out_rdata <= (n_out_kind == KIND_RESP) ? r_job.read_data : '0;
            r_out_cs    <= (n_out_kind == KIND_RESP) ? r_job.cs_resp : r_job.cs_act;
            r_out_irq   <= (n_out_kind == KIND_RESP) ? r_job.irq_resp : r_job.irq_act;
            r_out_last  <= (n_out_kind == KIND_RESP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
            r_rem       <= '0;
            r_ptr       <= W_FIFO;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (o_q_pop) begin
                r_rem <= i_q_head.data_len;
                r_ptr <= i_q_head.upper ? (W_FIFO + W_FIFO_UPPER) : W_FIFO;
            end else if ((r_state == B_DATA) && out_free) begin
                r_rem <= r_rem - 7'(d_cnt);
                r_ptr <= r_ptr + 6'd1;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_kind       = r_out_kind;
    assign o_spi_bytes  = r_out_bytes;
    assign o_byte_count = r_out_cnt;
    assign o_read_data  = r_out_rdata;
    assign o_cs_lines   = r_out_cs;
    assign o_irq_level  = r_out_irq;
    assign o_last       = r_out_last;

`ifndef SYNTHESIS
    a_group_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind) |-> (!o_last && o_byte_count != 3'd0 && o_byte_count <= 3'd4
                                 && o_read_data == '0))
        else $error("byte group with bad count or marker");

    a_resp_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_kind) |-> (o_last && o_byte_count == 3'd0 && o_spi_bytes == '0))
        else $error("response carries spi bytes");

    a_data_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DATA || r_state == B_FETCH) |-> (r_rem != '0))
        else $error("data phase with nothing left");

    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_xfer_done |=> !o_xfer_done)
        else $error("transfer completion repeated");
`endif

endmodule

// ===== hw/rtl/spi_master_register_block.sv =====
// top level of the spi master register block
//
//  channel   direction  handshake            payload
//  request   in         i_valid / o_stall    i_op, i_reg_word, i_write_data
//  result    out        o_valid / i_stall    o_kind, o_spi_bytes, o_byte_count,
//                                            o_read_data, o_cs_lines, o_irq_level, o_last
//
// a plain read or write passes the front end (register file read, then update), then the
// queue, the back end and the output register; the next request waits for the update
// a transfer emits up to one command group and one address group, then one data group
// per fifo word (fifo word read then emit), then the response: at most 19 results
// the front end holds off new requests until a started transfer has sent its response
// i_rst_n is synchronous; control registers and chip selects reset, stored words read 0
// i_stall holds the output register; the two-entry queue keeps the front end accepting
module spi_master_register_block (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [5:0]  i_reg_word,
    input  logic [31:0] i_write_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_kind,
    output logic [31:0] o_spi_bytes,
    output logic [2:0]  o_byte_count,
    output logic [31:0] o_read_data,
    output logic [5:0]  o_cs_lines,
    output logic        o_irq_level,
    output logic        o_last
);
    import smrb_pkg::*;

    // front to register file
    logic        mem_we;
    logic [5:0]  mem_waddr;
    logic [31:0] mem_wdata;
    logic [31:0] mem_rdata_a;

    // back to register file, fifo words
    logic [5:0]  mem_raddr_b;
    logic [31:0] mem_rdata_b;

    // request queue
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    t_job q_job;
    t_job q_head;

    // transfer finished, releases the front end
    logic xfer_done;

    smrb_regmem u_regmem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (i_reg_word),
        .o_rdata_a (mem_rdata_a),
        .i_raddr_b (mem_raddr_b),
        .o_rdata_b (mem_rdata_b)
    );

    // front: accept, register update, classification
    smrb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_op         (i_op),
        .i_reg_word   (i_reg_word),
        .i_write_data (i_write_data),
        .i_mem_rdata  (mem_rdata_a),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_job      (q_job),
        .i_xfer_done  (xfer_done)
    );

    smrb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty)
    );

    // back: byte groups and responses
    smrb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_head     (q_head),
        .o_q_pop      (q_pop),
        .o_mem_raddr  (mem_raddr_b),
        .i_mem_rdata  (mem_rdata_b),
        .o_xfer_done  (xfer_done),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_spi_bytes  (o_spi_bytes),
        .o_byte_count (o_byte_count),
        .o_read_data  (o_read_data),
        .o_cs_lines   (o_cs_lines),
        .o_irq_level  (o_irq_level),
        .o_last       (o_last)
    );

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench for the spi master register block: directed table plus random traffic
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import smrb_pkg::*;

    // one result as it leaves the block
    typedef struct packed {
        t_kind       kind;
        logic [31:0] spi_bytes;
        logic [2:0]  byte_count;
        logic [31:0] read_data;
        logic [5:0]  cs_lines;
        logic        irq_level;
        logic        last;
    } t_result;

    // one row of the directed table; pinned rows carry a response typed in by hand
    typedef struct packed {
        t_op         op;
        logic [5:0]  word;
        logic [31:0] data;
        logic        pinned;
        logic [31:0] rd;
        logic [5:0]  cs;
        logic        irq;
    } t_row;

    localparam int DIRECTED_ROWS = 27;
    localparam int RANDOM_ITEMS  = 250;
    localparam int TAIL_CYCLES   = 40;
    localparam int TIMEOUT_NS    = 3_000_000;

    // directed part: reset values, a full transfer, status and clear/set words,
    // data too long in the upper half, an unaligned address and dma enabled
    localparam t_row DIRECTED [DIRECTED_ROWS] = '{
        '{OP_READ,  W_MISC,  32'h0000_0000, 1'b1, 32'h0000_003F, 6'h3F, 1'b0},
        '{OP_WRITE, W_FIFO,  32'hFFFF_FFFF, 1'b0, 32'h0, 6'h0, 1'b0},
        '{OP_WRITE, 6'd46,   32'h1234_5678, 1'b0, 32'h0, 6'h0, 1'b0},
        '{OP_WRITE, W_MISC,  32'h0000_0000, 1'b0, 32'h0, 6'h0, 1'b0},
        '{OP_WRITE, W_USER2, 32'h7000_00A5, 1'b0, 32'h0, 6'h0, 1'b0},
        '{OP_WRITE, W_USER1, 32'hF800_0000, 1'b0, 32'h0, 6'h0, 1'b0},
        '{OP_WRITE, W_ADDR,  32'h0102_0304, 1'b0, 32'h0, 6'h0, 1'b0},
        '{OP_WRITE, W_DLEN,  32'h0000_001F, 1'b0, 32'h0, 6'h0, 1'b0},
        '{OP_WRITE, W_USER,  32'hC800_0000, 1'b0, 32'h0, 6'h0, 1'b0},
        '{OP_WRITE, W_CMD,   32'h0180_0000, 1'b0, 32'h0, 6'h0, 1'b0},
        '{OP_READ,  W_RAW,   32'h0000_0000, 1'b1, 32'h0000_1000, 6'h3F, 1'b0},
        '{OP_WRITE, W_ENA,   32'hFFFF_FFFF, 1'b0, 32'h0, 6'h0, 1'b0},
        '{OP_WRITE, W_ST,    32'hFFFF_FFFF, 1'b0, 32'h0, 6'h0, 1'b0},
        '{OP_READ,  W_ST,    32'h0000_0000, 1'b1, 32'h0000_1000, 6'h3F, 1'b1},
        '{OP_WRITE, W_CLR,   32'hFFFF_FFFF, 1'b0, 32'h0, 6'h0, 1'b0},
        '{OP_WRITE, W_SET,   32'h8000_0001, 1'b0, 32'h0, 6'h0, 1'b0},
        '{OP_WRITE, W_MISC,  32'h4000_1F80, 1'b0, 32'h0, 6'h0, 1'b0},
        '{OP_WRITE, W_DLEN,  32'h0003_FFFF, 1'b0, 32'h0, 6'h0, 1'b0},
        '{OP_WRITE, W_USER,  32'h0A00_0000, 1'b0, 32'h0, 6'h0, 1'b0},
        '{OP_WRITE, W_CMD,   32'h0100_0000, 1'b0, 32'h0, 6'h0, 1'b0},
        '{OP_WRITE, W_USER1, 32'h1000_0000, 1'b0, 32'h0, 6'h0, 1'b0},
        '{OP_WRITE, W_USER,  32'h4000_0000, 1'b0, 32'h0, 6'h0, 1'b0},
        '{OP_WRITE, W_CMD,   32'h0100_0000, 1'b0, 32'h0, 6'h0, 1'b0},
        '{OP_WRITE, W_DMA,   32'h1000_0000, 1'b0, 32'h0, 6'h0, 1'b0},
        '{OP_WRITE, W_USER,  32'h0800_0000, 1'b0, 32'h0, 6'h0, 1'b0},
        '{OP_WRITE, W_CMD,   32'hFFFF_FFFF, 1'b0, 32'h0, 6'h0, 1'b0},
        '{OP_READ,  W_CMD,   32'h0000_0000, 1'b1, 32'h0000_0000, 6'h3F, 1'b1}
    };

    // every block input starts at a known value
    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic        i_op         = 1'b0;
    logic [5:0]  i_reg_word   = 6'd0;
    logic [31:0] i_write_data = 32'd0;
    logic        i_stall      = 1'b0;

    logic        o_stall;
    logic        o_valid;
    logic        o_kind;
    logic [31:0] o_spi_bytes;
    logic [2:0]  o_byte_count;
    logic [31:0] o_read_data;
    logic [5:0]  o_cs_lines;
    logic        o_irq_level;
    logic        o_last;

    spi_master_register_block dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_op         (i_op),
        .i_reg_word   (i_reg_word),
        .i_write_data (i_write_data),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_spi_bytes  (o_spi_bytes),
        .o_byte_count (o_byte_count),
        .o_read_data  (o_read_data),
        .o_cs_lines   (o_cs_lines),
        .o_irq_level  (o_irq_level),
        .o_last       (o_last)
    );

    // shadow copy of the register file and chip select levels
    logic [31:0] shadow_regs [REG_WORDS];
    logic [5:0]  shadow_cs;

    // results the block still owes, oldest first
    t_result expected_results [$];

    int requests_sent     = 0;
    int results_seen      = 0;
    int groups_seen       = 0;
    int transfers_started = 0;
    int error_count       = 0;
    int burst_left        = 1;

    // hand-typed response for the request being sent, if any
    logic        pin_next = 1'b0;
    logic [31:0] pin_rd;
    logic [5:0]  pin_cs;
    logic        pin_irq;

    // receiver stall pattern state
    int stall_mode      = 0;
    int stall_mode_left = 0;
    int stall_run       = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // hard stop far beyond the slowest legal run
    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // chip select levels for the current misc word
    function automatic logic [5:0] cs_levels(input logic active);
        logic [5:0] lvl;
        logic       sel;
        lvl = '0;
        for (int c = 0; c < CS_LINES; c++) begin
            sel    = active && !shadow_regs[W_MISC][c];
            lvl[c] = !sel ^ shadow_regs[W_MISC][c + 7];
        end
        return lvl;
    endfunction

    // left-aligned phase value to bytes, first byte lowest
    function automatic logic [31:0] phase_bytes(input logic [31:0] value, input int unsigned n);
        logic [31:0] out;
        out = '0;
        for (int unsigned i = 0; i < n; i++)
            out |= ((value >> (24 - 8 * i)) & 32'hFF) << (8 * i);
        return out;
    endfunction

    // cs and irq are taken at the moment the result is produced
    function automatic void push_result(input t_kind kind, input logic [31:0] bytes,
                                        input logic [2:0] cnt, input logic [31:0] rd,
                                        input logic last);
        t_result r;
        r.kind       = kind;
        r.spi_bytes  = bytes;
        r.byte_count = cnt;
        r.read_data  = rd;
        r.cs_lines   = shadow_cs;
        r.irq_level  = (shadow_regs[W_RAW] & shadow_regs[W_ENA]) != 0;
        r.last       = last;
        expected_results.push_back(r);
    endfunction

    // predicts every result one register access causes and updates the shadow state
    function automatic void predict_access(input t_op op, input logic [5:0] word,
                                           input logic [31:0] data);
        logic [31:0] user;
        logic [31:0] len;
        logic [31:0] cap;
        logic [31:0] fifo_word;
        int unsigned cbits;
        int unsigned abits;
        int unsigned start;
        int unsigned cnt;
        if (op == OP_READ) begin
            // status word reads back raw and enable, everything else the stored word
            push_result(KIND_RESP, '0, '0,
                        (word == W_ST) ? (shadow_regs[W_RAW] & shadow_regs[W_ENA])
                                       : shadow_regs[word], 1'b1);
            return;
        end
        if (word == W_CLR)
            shadow_regs[W_RAW] &= ~data;
        else if (word == W_SET)
            shadow_regs[W_RAW] |= data;
        else
            shadow_regs[word] = data;
        if (word == W_CMD) begin
            shadow_regs[W_CMD][B_CMD_UPDATE] = 1'b0;
            if (data[B_CMD_USR]) begin
                transfers_started++;
                user      = shadow_regs[W_USER];
                shadow_cs = cs_levels(1'b1);
                cbits = user[B_USER_CMD]  ? shadow_regs[W_USER2][31:28] + 1 : 0;
                abits = user[B_USER_ADDR] ? shadow_regs[W_USER1][31:27] + 1 : 0;
                // a phase that is not whole bytes suppresses every byte of the transfer
                if (cbits % 8 == 0 && abits % 8 == 0) begin
                    if (cbits != 0)
                        push_result(KIND_SPI,
                                    phase_bytes(shadow_regs[W_USER2] << (32 - cbits),
                                                cbits / 8), 3'(cbits / 8), '0, 1'b0);
                    if (abits != 0)
                        push_result(KIND_SPI, phase_bytes(shadow_regs[W_ADDR], abits / 8),
                                    3'(abits / 8), '0, 1'b0);
                    len = user[B_USER_DATA] ? ((shadow_regs[W_DLEN] & 32'h3FFFF) + 8) / 8 : 0;
                    if (len != 0 && shadow_regs[W_DMA][B_DMA_EN])
                        len = 0;
                    start = user[B_USER_HALF] ? 8 : 0;
                    cap   = (FIFO_BYTES > start * 4) ? FIFO_BYTES - start * 4 : 0;
                    if (len > cap)
                        len = cap;
                    for (int unsigned g = 0; g * 4 < len; g++) begin
                        cnt       = (len - g * 4 > 4) ? 4 : len - g * 4;
                        fifo_word = shadow_regs[6'(W_FIFO + start + g)];
                        if (cnt < 4)
                            fifo_word &= (32'h1 << (8 * cnt)) - 1;
                        push_result(KIND_SPI, fifo_word, 3'(cnt), '0, 1'b0);
                    end
                end
                shadow_cs = cs_levels(shadow_regs[W_MISC][B_MISC_KEEP]);
                shadow_regs[W_CMD] = '0;
                shadow_regs[W_RAW][B_RAW_DONE] = 1'b1;
            end
        end
        push_result(KIND_RESP, '0, '0, '0, 1'b1);
    endfunction

    function automatic string result_text(input t_result r);
        return $sformatf("kind=%0d bytes=%h count=%0d read=%h cs=%h irq=%0b last=%0b",
                         r.kind, r.spi_bytes, r.byte_count, r.read_data, r.cs_lines,
                         r.irq_level, r.last);
    endfunction

    // offers one request, holds it through stalls, then predicts it once accepted;
    // the sender idles between bursts of random length
    task automatic send_request(input t_op op, input logic [5:0] word, input logic [31:0] data);
        t_result r;
        i_valid      <= 1'b1;
        i_op         <= op;
        i_reg_word   <= word;
        i_write_data <= data;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_access(op, word, data);
        if (pin_next) begin
            // hand-typed response replaces the predicted one
            r           = expected_results.pop_back();
            r.read_data = pin_rd;
            r.cs_lines  = pin_cs;
            r.irq_level = pin_irq;
            expected_results.push_back(r);
            pin_next = 1'b0;
        end
        requests_sent++;
        burst_left--;
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
    endtask

    // sender goes quiet until the block has returned everything it owes
    task automatic hold_until_drained();
        if (i_valid) i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // receiver stall: quiet stretches, light and heavy random stalls, and stall runs
    always @(posedge i_clk) begin
        if (stall_mode_left == 0) begin
            stall_mode      = $urandom_range(0, 3);
            stall_mode_left = $urandom_range(32, 128);
        end else begin
            stall_mode_left--;
        end
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= 1'($urandom_range(0, 1));
            default: begin
                if (stall_run > 0) begin
                    i_stall <= 1'b1;
                    stall_run--;
                end else begin
                    i_stall <= 1'b0;
                    if ($urandom_range(0, 3) == 0) stall_run = $urandom_range(1, 6);
                end
            end
        endcase
    end

    // every accepted result is matched against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            got.kind       = t_kind'(o_kind);
            got.spi_bytes  = o_spi_bytes;
            got.byte_count = o_byte_count;
            got.read_data  = o_read_data;
            got.cs_lines   = o_cs_lines;
            got.irq_level  = o_irq_level;
            got.last       = o_last;
            results_seen++;
            if (got.kind == KIND_SPI) groups_seen++;
            if (expected_results.size() == 0) begin
                if (error_count < 10) $display("unexpected result: %s", result_text(got));
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.kind !== want.kind || got.spi_bytes !== want.spi_bytes ||
                    got.byte_count !== want.byte_count || got.read_data !== want.read_data ||
                    got.cs_lines !== want.cs_lines || got.irq_level !== want.irq_level ||
                    got.last !== want.last) begin
                    if (error_count < 10) begin
                        $display("mismatch on result %0d", results_seen);
                        $display("  expected %s", result_text(want));
                        $display("  actual   %s", result_text(got));
                    end
                    error_count++;
                end
            end
        end
    end

    initial begin : stimulus
        int          pick;
        logic [3:0]  cmd_f;
        logic [4:0]  addr_f;
        logic [31:0] v;

        // shadow state after reset: only misc is nonzero, every line inactive
        for (int i = 0; i < REG_WORDS; i++) shadow_regs[i] = '0;
        shadow_regs[W_MISC] = MISC_RESET;
        shadow_cs = cs_levels(1'b0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            pin_next = DIRECTED[r].pinned;
            pin_rd   = DIRECTED[r].rd;
            pin_cs   = DIRECTED[r].cs;
            pin_irq  = DIRECTED[r].irq;
            send_request(DIRECTED[r].op, DIRECTED[r].word, DIRECTED[r].data);
        end
        hold_until_drained();

        // dma was left on by the table; turn it off so data phases come back
        send_request(OP_WRITE, W_DMA, 32'h0);

        // random part: mostly complete transfer setups, the rest raw register noise
        while (requests_sent < DIRECTED_ROWS + 1 + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                repeat ($urandom_range(0, 4))
                    send_request(OP_WRITE, W_FIFO + 6'($urandom_range(0, 15)), $urandom);
                // byte-aligned command and address lengths most of the time
                case ($urandom_range(0, 4))
                    0, 1: cmd_f = 4'd7;
                    2, 3: cmd_f = 4'd15;
                    default: cmd_f = 4'($urandom);
                endcase
                case ($urandom_range(0, 5))
                    0: addr_f = 5'd7;
                    1: addr_f = 5'd15;
                    2: addr_f = 5'd23;
                    3, 4: addr_f = 5'd31;
                    default: addr_f = 5'($urandom);
                endcase
                send_request(OP_WRITE, W_USER2, {cmd_f, 28'($urandom)});
                send_request(OP_WRITE, W_USER1, {addr_f, 27'($urandom)});
                send_request(OP_WRITE, W_ADDR, $urandom);
                // short data most of the time, long or saturating now and then
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    v = $urandom_range(0, 40);
                else if (pick < 9)
                    v = $urandom_range(0, 511);
                else
                    v = $urandom;
                send_request(OP_WRITE, W_DLEN, v);
                send_request(OP_WRITE, W_USER, $urandom);
                if ($urandom_range(0, 3) == 0) begin
                    v = $urandom;
                    v[B_DMA_EN] = ($urandom_range(0, 3) == 0);
                    send_request(OP_WRITE, W_DMA, v);
                end
                if ($urandom_range(0, 4) == 0) send_request(OP_WRITE, W_MISC, $urandom);
                if ($urandom_range(0, 4) == 0) send_request(OP_WRITE, W_ENA, $urandom);
                v = $urandom;
                if ($urandom_range(0, 7) != 0) v[B_CMD_USR] = 1'b1;
                send_request(OP_WRITE, W_CMD, v);
                // read back the status side now and then
                case ($urandom_range(0, 5))
                    0: send_request(OP_READ, W_RAW, $urandom);
                    1: send_request(OP_READ, W_ST, $urandom);
                    2: send_request(OP_READ, W_CMD, $urandom);
                    default: ;
                endcase
                if ($urandom_range(0, 3) == 0) send_request(OP_WRITE, W_CLR, $urandom);
                if ($urandom_range(0, 9) == 0) hold_until_drained();
            end else begin
                send_request(t_op'($urandom_range(0, 1)), 6'($urandom_range(0, 63)), $urandom);
            end
        end

        // let the last transfer finish, then give the block a tail to misbehave in
        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d register requests, %0d of them starting a transfer",
                 requests_sent, transfers_started);
        $display("checked %0d results including %0d spi byte groups, %0d failures",
                 results_seen, groups_seen, error_count);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
